/* src/fht_pkg.sv */
// Shared constants, codes and helper functions of the chained hash table.
package fht_pkg;

   localparam int MAX_BUCKETS   = 1024;
   localparam int NODE_SLOTS    = 256;
   localparam int KEY_MAX_BYTES = 8;

   localparam int BKT_W    = $clog2(MAX_BUCKETS);
   localparam int SLOT_W   = $clog2(NODE_SLOTS);
   localparam int HEAD_W   = SLOT_W + 1;   // valid bit on top of the slot
   localparam int PREV_W   = BKT_W + 1;    // head flag on top of bucket or slot
   localparam int CNT_W    = $clog2(NODE_SLOTS + 1);
   localparam int KEY_W    = 64;
   localparam int HASH_W   = 32;
   localparam int CFG_W    = 4;
   localparam int NBYTE_W  = 4;

   localparam logic [HASH_W-1:0] FNV_BASIS = 32'd2166136261;
   localparam logic [HASH_W-1:0] FNV_PRIME = 32'd16777619;

   localparam logic [2:0] OP_FIND     = 3'd0;
   localparam logic [2:0] OP_ADD      = 3'd1;
   localparam logic [2:0] OP_DEL_KEY  = 3'd2;
   localparam logic [2:0] OP_DEL_SLOT = 3'd3;
   localparam logic [2:0] OP_EMPTY    = 3'd4;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_KEY     = 2'd1;
   localparam logic [1:0] ST_SLOT    = 2'd2;

   localparam logic CSR_BUCKET_BITS = 1'b0;
   localparam logic CSR_KEY_BYTES   = 1'b1;

   // clamp the key byte count to 1..KEY_MAX_BYTES
   function automatic logic [NBYTE_W-1:0] eff_bytes(input logic [CFG_W-1:0] kb);
      if (kb == '0) begin
         return NBYTE_W'(1);
      end else if (kb > CFG_W'(KEY_MAX_BYTES)) begin
         return NBYTE_W'(KEY_MAX_BYTES);
      end
      return kb;
   endfunction

   function automatic logic [KEY_W-1:0] key_mask(input logic [NBYTE_W-1:0] n);
      logic [KEY_W-1:0] m;
      m = '0;
      for (int i = 0; i < KEY_W / 8; i++) begin
         if (NBYTE_W'(i) < n) begin
            m[i*8 +: 8] = 8'hFF;
         end
      end
      return m;
   endfunction

   // low hash bits under the bucket mask, saturated at the table size
   function automatic logic [BKT_W-1:0] bucket_of(input logic [HASH_W-1:0] h,
                                                  input logic [CFG_W-1:0]  bb);
      logic [BKT_W-1:0] m;
      m = '0;
      for (int i = 0; i < BKT_W; i++) begin
         if (CFG_W'(i) < bb || (i == 0)) begin
            m[i] = 1'b1;
         end
      end
      return h[BKT_W-1:0] & m;
   endfunction

endpackage

/* src/fnv_chained_hash_table.sv */
// Top level of the chained hash table engine: sequencer, memories and hash unit.
//
// Hash table over 256 node slots and up to 1024 buckets, each bucket a doubly
// linked chain kept in synchronous memories (bucket heads, next links, previous
// links, stored key and hash). Keys are hashed with 32-bit FNV-1a by a serial
// unit, one byte per cycle. One operation is in flight at a time; req_stall
// is high while it runs. A lookup reads the bucket head and makes one memory
// read per chain node visited; an add then writes the new node and, if the
// chain was not empty, the old head's previous link; a delete reads and
// writes back the links; the result is then handed off to the output register
// once that is free. A delete by handle or an is-empty query skips hashing.
// The next request is taken while the previous result still waits in the
// output register. After reset a clearing pass empties all 1024 bucket heads,
// during which no request is accepted; configuration writes are taken at any
// time, but should be made only while idle.
module fnv_chained_hash_table (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic                            csr_addr,
   input  logic [fht_pkg::CFG_W-1:0]       csr_wdata,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [2:0]                      req_op,
   input  logic [fht_pkg::KEY_W-1:0]       req_key,
   input  logic [7:0]                      req_slot,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [1:0]                      rsp_status,
   output logic [7:0]                      rsp_found_slot,
   output logic                            rsp_is_empty,
   output logic [fht_pkg::HASH_W-1:0]      rsp_hash_value
);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_HASH, S_HEAD, S_CMP, S_UN_RD, S_UN_WR,
      S_LINK1, S_LINK2, S_DONE
   } state_type;

   localparam int SW = fht_pkg::SLOT_W;
   localparam int BW = fht_pkg::BKT_W;
   localparam int KHW = fht_pkg::KEY_W + fht_pkg::HASH_W;

   state_type                     st_ff, st_in;
   logic [fht_pkg::CFG_W-1:0]     bb_ff, kb_ff;
   logic [2:0]                    op_ff, op_in;
   logic [fht_pkg::KEY_W-1:0]     key_ff, key_in;
   logic [SW-1:0]                 slot_ff, slot_in;
   logic [fht_pkg::HASH_W-1:0]    hash_ff, hash_in;
   logic [BW-1:0]                 bkt_ff, bkt_in;
   logic [SW-1:0]                 cur_ff, cur_in;
   logic [fht_pkg::HEAD_W-1:0]    head_ff, head_in;
   logic [1:0]                    status_ff, status_in;
   logic [SW-1:0]                 found_ff, found_in;
   logic [fht_pkg::HASH_W-1:0]    hv_ff, hv_in;
   logic [BW-1:0]                 clr_ff, clr_in;
   logic [fht_pkg::CNT_W-1:0]     count_ff, count_in;
   logic [fht_pkg::NODE_SLOTS-1:0] linked_ff, linked_in;
   logic                          rv_ff, rv_in;
   logic [1:0]                    rst_ff, rst_in;
   logic [7:0]                    rfs_ff, rfs_in;
   logic                          rie_ff, rie_in;
   logic [fht_pkg::HASH_W-1:0]    rhv_ff, rhv_in;

   // memory ports
   logic                          hd_we;
   logic [BW-1:0]                 hd_wa, hd_ra;
   logic [fht_pkg::HEAD_W-1:0]    hd_wd, hd_rd;
   logic                          nx_we;
   logic [SW-1:0]                 nx_wa, nx_ra;
   logic [fht_pkg::HEAD_W-1:0]    nx_wd, nx_rd;
   logic                          pv_we;
   logic [SW-1:0]                 pv_wa, pv_ra;
   logic [fht_pkg::PREV_W-1:0]    pv_wd, pv_rd;
   logic                          kh_we;
   logic [SW-1:0]                 kh_wa, kh_ra;
   logic [KHW-1:0]                kh_wd, kh_rd;

   logic                          fnv_start, fnv_done;
   logic [fht_pkg::HASH_W-1:0]    fnv_hash;
   logic                          req_acc, rsp_acc, out_free;
   logic [fht_pkg::KEY_W-1:0]     kmask;
   logic [BW-1:0]                 bkt_new;
   logic                          match;

   fht_ram #(.WIDTH(fht_pkg::HEAD_W), .DEPTH(fht_pkg::MAX_BUCKETS)) u_head (
      .clock(clock), .we(hd_we), .waddr(hd_wa), .wdata(hd_wd), .raddr(hd_ra), .rdata(hd_rd));
   fht_ram #(.WIDTH(fht_pkg::HEAD_W), .DEPTH(fht_pkg::NODE_SLOTS)) u_next (
      .clock(clock), .we(nx_we), .waddr(nx_wa), .wdata(nx_wd), .raddr(nx_ra), .rdata(nx_rd));
   fht_ram #(.WIDTH(fht_pkg::PREV_W), .DEPTH(fht_pkg::NODE_SLOTS)) u_prev (
      .clock(clock), .we(pv_we), .waddr(pv_wa), .wdata(pv_wd), .raddr(pv_ra), .rdata(pv_rd));
   fht_ram #(.WIDTH(KHW), .DEPTH(fht_pkg::NODE_SLOTS)) u_keyhash (
      .clock(clock), .we(kh_we), .waddr(kh_wa), .wdata(kh_wd), .raddr(kh_ra), .rdata(kh_rd));

   // the hash unit loads the masked key of the beat being accepted
   fht_fnv u_fnv (
      .clock(clock), .reset(reset), .start(fnv_start), .key(key_in),
      .nbytes(fht_pkg::eff_bytes(kb_ff)), .done(fnv_done), .hash(fnv_hash));

   assign req_stall = (st_ff != S_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign rsp_acc   = rv_ff && !rsp_stall;
   assign out_free  = !rv_ff || !rsp_stall;
   assign kmask     = fht_pkg::key_mask(fht_pkg::eff_bytes(kb_ff));
   assign bkt_new   = fht_pkg::bucket_of(fnv_hash, bb_ff);
   // compare stored keys under the current byte mask
   assign match     = (kh_rd[fht_pkg::HASH_W-1:0] == hash_ff) &&
                      (((kh_rd[KHW-1:fht_pkg::HASH_W] ^ key_ff) & kmask) == '0);

   always_comb begin
      st_in = st_ff;   op_in = op_ff;     key_in = key_ff;   slot_in = slot_ff;
      hash_in = hash_ff; bkt_in = bkt_ff; cur_in = cur_ff;   head_in = head_ff;
      status_in = status_ff; found_in = found_ff; hv_in = hv_ff; clr_in = clr_ff;
      count_in = count_ff; linked_in = linked_ff;
      rv_in = rv_ff && !rsp_acc;
      rst_in = rst_ff; rfs_in = rfs_ff; rie_in = rie_ff; rhv_in = rhv_ff;
      fnv_start = 1'b0;
      hd_we = 1'b0; hd_wa = bkt_ff;  hd_wd = '0; hd_ra = bkt_new;
      nx_we = 1'b0; nx_wa = slot_ff; nx_wd = '0; nx_ra = cur_ff;
      pv_we = 1'b0; pv_wa = slot_ff; pv_wd = '0; pv_ra = cur_ff;
      kh_we = 1'b0; kh_wa = slot_ff; kh_wd = {key_ff, hash_ff}; kh_ra = cur_ff;

      unique case (st_ff)
         S_CLEAR: begin
            // empty one bucket head per cycle
            hd_we = 1'b1;
            hd_wa = clr_ff;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == BW'(fht_pkg::MAX_BUCKETS - 1)) begin
               st_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_acc) begin
               op_in = req_op;
               key_in = req_key & kmask;
               slot_in = req_slot;
               cur_in = req_slot;
               status_in = fht_pkg::ST_OK;
               found_in = '0;
               hv_in = '0;
               priority case (1'b1)
                  (req_op == fht_pkg::OP_FIND || req_op == fht_pkg::OP_ADD ||
                   req_op == fht_pkg::OP_DEL_KEY): st_in = S_HASH;
                  (req_op == fht_pkg::OP_DEL_SLOT): begin
                     if (linked_ff[req_slot]) begin
                        st_in = S_UN_RD;
                     end else begin
                        status_in = fht_pkg::ST_SLOT;
                        st_in = S_DONE;
                     end
                  end
                  (req_op == fht_pkg::OP_EMPTY): st_in = S_DONE;
                  default: begin
                     status_in = fht_pkg::ST_SLOT;
                     st_in = S_DONE;
                  end
               endcase
            end
         end
         S_HASH: begin
            if (fnv_done) begin
               hash_in = fnv_hash;
               hv_in = fnv_hash;
               bkt_in = bkt_new;
               if (op_ff == fht_pkg::OP_ADD && linked_ff[slot_ff]) begin
                  status_in = fht_pkg::ST_SLOT;
                  st_in = S_DONE;
               end else begin
                  st_in = S_HEAD;   // head read issued this cycle
               end
            end
         end
         S_HEAD: begin
            head_in = hd_rd;
            cur_in = hd_rd[SW-1:0];
            nx_ra = hd_rd[SW-1:0];
            kh_ra = hd_rd[SW-1:0];
            if (hd_rd[SW]) begin
               st_in = S_CMP;
            end else if (op_ff == fht_pkg::OP_ADD) begin
               st_in = S_LINK1;
            end else begin
               status_in = fht_pkg::ST_KEY;
               st_in = S_DONE;
            end
         end
         S_CMP: begin
            nx_ra = nx_rd[SW-1:0];
            kh_ra = nx_rd[SW-1:0];
            if (match) begin
               unique case (op_ff)
                  fht_pkg::OP_ADD: begin
                     status_in = fht_pkg::ST_KEY;
                     st_in = S_DONE;
                  end
                  fht_pkg::OP_DEL_KEY: begin
                     found_in = cur_ff;
                     st_in = S_UN_RD;
                  end
                  default: begin
                     found_in = cur_ff;
                     st_in = S_DONE;
                  end
               endcase
            end else if (nx_rd[SW]) begin
               cur_in = nx_rd[SW-1:0];   // advance along the chain
            end else if (op_ff == fht_pkg::OP_ADD) begin
               st_in = S_LINK1;
            end else begin
               status_in = fht_pkg::ST_KEY;
               st_in = S_DONE;
            end
         end
         S_UN_RD: begin
            st_in = S_UN_WR;   // prev, next and hash of cur read this cycle
         end
         S_UN_WR: begin
            if (op_ff == fht_pkg::OP_DEL_SLOT) begin
               hv_in = kh_rd[fht_pkg::HASH_W-1:0];
            end
            if (pv_rd[BW]) begin
               hd_we = 1'b1;
               hd_wa = pv_rd[BW-1:0];
               hd_wd = nx_rd;
            end else begin
               nx_we = 1'b1;
               nx_wa = pv_rd[SW-1:0];
               nx_wd = nx_rd;
            end
            if (nx_rd[SW]) begin
               pv_we = 1'b1;
               pv_wa = nx_rd[SW-1:0];
               pv_wd = pv_rd;
            end
            linked_in[cur_ff] = 1'b0;
            count_in = count_ff - 1'b1;
            st_in = S_DONE;
         end
         S_LINK1: begin
            // new slot goes to the head of its bucket
            kh_we = 1'b1;
            nx_we = 1'b1;
            nx_wd = head_ff;
            pv_we = 1'b1;
            pv_wd = {1'b1, bkt_ff};
            hd_we = 1'b1;
            hd_wd = {1'b1, slot_ff};
            linked_in[slot_ff] = 1'b1;
            count_in = count_ff + 1'b1;
            st_in = head_ff[SW] ? S_LINK2 : S_DONE;
         end
         S_LINK2: begin
            pv_we = 1'b1;
            pv_wa = head_ff[SW-1:0];
            pv_wd = fht_pkg::PREV_W'(slot_ff);
            st_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               rv_in = 1'b1;
               rst_in = status_ff;
               rfs_in = 8'(found_ff);
               rie_in = (count_ff == '0);
               rhv_in = hv_ff;
               st_in = S_IDLE;
            end
         end
         default: st_in = S_IDLE;
      endcase

      // start the hash unit on entry to the hash state
      fnv_start = (st_ff == S_IDLE) && (st_in == S_HASH);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff     <= S_CLEAR;
         clr_ff    <= '0;
         count_ff  <= '0;
         linked_ff <= '0;
         rv_ff     <= 1'b0;
         bb_ff     <= fht_pkg::CFG_W'(10);
         kb_ff     <= fht_pkg::CFG_W'(8);
      end else begin
         st_ff     <= st_in;
         clr_ff    <= clr_in;
         count_ff  <= count_in;
         linked_ff <= linked_in;
         rv_ff     <= rv_in;
         if (csr_we) begin
            unique case (csr_addr)
               fht_pkg::CSR_BUCKET_BITS: bb_ff <= csr_wdata;
               fht_pkg::CSR_KEY_BYTES:   kb_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
      op_ff <= op_in;   key_ff <= key_in;   slot_ff <= slot_in;
      hash_ff <= hash_in; bkt_ff <= bkt_in; cur_ff <= cur_in;   head_ff <= head_in;
      status_ff <= status_in; found_ff <= found_in; hv_ff <= hv_in;
      rst_ff <= rst_in; rfs_ff <= rfs_in; rie_ff <= rie_in; rhv_ff <= rhv_in;
   end

   assign rsp_valid      = rv_ff;
   assign rsp_status     = rst_ff;
   assign rsp_found_slot = rfs_ff;
   assign rsp_is_empty   = rie_ff;
   assign rsp_hash_value = rhv_ff;

   property p_count_matches;
      @(posedge clock) disable iff (reset) 32'($countones(linked_ff)) == 32'(count_ff);
   endproperty
   a_count_matches: assert property (p_count_matches) else $error("linked count mismatch");

   property p_no_accept_clear;
      @(posedge clock) disable iff (reset) st_ff == S_CLEAR |-> !req_acc;
   endproperty
   a_no_accept_clear: assert property (p_no_accept_clear) else $error("request during clear");

   property p_rsp_from_done;
      @(posedge clock) disable iff (reset) $rose(rv_ff) |-> $past(st_ff) == S_DONE;
   endproperty
   a_rsp_from_done: assert property (p_rsp_from_done) else $error("result outside done");

   property p_link_free_slot;
      @(posedge clock) disable iff (reset) st_ff == S_LINK1 |-> !linked_ff[slot_ff];
   endproperty
   a_link_free_slot: assert property (p_link_free_slot) else $error("linking a linked slot");

endmodule

/* src/fht_ram.sv */
// Generic single-write, single-read memory with registered read data.
module fht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

/* src/fht_fnv.sv */
// Serial FNV-1a hash unit, one key byte per cycle.
module fht_fnv (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [fht_pkg::KEY_W-1:0]       key,
   input  logic [fht_pkg::NBYTE_W-1:0]     nbytes,
   output logic                            done,
   output logic [fht_pkg::HASH_W-1:0]      hash
);

   logic [fht_pkg::HASH_W-1:0]  v_ff, v_in;
   logic [fht_pkg::KEY_W-1:0]   key_ff;
   logic [fht_pkg::NBYTE_W-1:0] cnt_ff;
   logic                        run_ff;
   logic                        done_ff;

   // one round: fold in the low byte, multiply by the prime
   assign v_in = fht_pkg::HASH_W'((v_ff ^ {24'd0, key_ff[7:0]}) * fht_pkg::FNV_PRIME);

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            v_ff   <= fht_pkg::FNV_BASIS;
            key_ff <= key;
            cnt_ff <= nbytes;
            run_ff <= 1'b1;
         end else if (run_ff) begin
            v_ff   <= v_in;
            key_ff <= key_ff >> 8;
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == fht_pkg::NBYTE_W'(1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign hash = v_ff;

   property p_no_start_busy;
      @(posedge clock) disable iff (reset) start |-> !run_ff;
   endproperty
   a_no_start_busy: assert property (p_no_start_busy) else $error("fnv restarted while busy");

   property p_done_after_run;
      @(posedge clock) disable iff (reset) $rose(done_ff) |-> $past(run_ff);
   endproperty
   a_done_after_run: assert property (p_done_after_run) else $error("fnv done without run");

   property p_cnt_nonzero;
      @(posedge clock) disable iff (reset) run_ff |-> cnt_ff != '0;
   endproperty
   a_cnt_nonzero: assert property (p_cnt_nonzero) else $error("fnv count underflow");

endmodule
